FILE: rtl/core/multi_list_table_engine_defines.svh
// Assertion macros for the bounded multi-list table engine.
// Included by the RTL files that carry concurrent assertions.
`ifndef MULTI_LIST_TABLE_ENGINE_DEFINES_SVH
`define MULTI_LIST_TABLE_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MLTE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mlte assertion failed");
`define MLTE_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("mlte assertion failed");
`else
`define MLTE_ASSERT(lbl, clk, rst, prop)
`define MLTE_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/mlte_pkg.sv
// Shared constants, codes and types of the multi-list table engine.
// No dependencies; used by the store, the top level and the testbench.
package mlte_pkg;
   localparam int SLOTS = 10;
   localparam int CAP   = 6;
   localparam int DEPTH = SLOTS * CAP;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(SLOTS);
   localparam int KW    = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CW    = $clog2(CAP + 1);
   localparam int NW    = $clog2(DEPTH + 1);

   localparam logic [3:0] K_CREATE        = 4'd0;
   localparam logic [3:0] K_APPEND        = 4'd1;
   localparam logic [3:0] K_POP           = 4'd2;
   localparam logic [3:0] K_DELETE        = 4'd3;
   localparam logic [3:0] K_RESIZE        = 4'd4;
   localparam logic [3:0] K_COUNT         = 4'd5;
   localparam logic [3:0] K_READ          = 4'd6;
   localparam logic [3:0] K_READ_SORT     = 4'd7;
   localparam logic [3:0] K_READ_ALL      = 4'd8;
   localparam logic [3:0] K_READ_ALL_SORT = 4'd9;
   localparam logic [3:0] K_CHECK         = 4'd10;

   localparam logic [3:0] STS_OK        = 4'd0;
   localparam logic [3:0] STS_BAD_POS   = 4'd1;
   localparam logic [3:0] STS_EXISTS    = 4'd2;
   localparam logic [3:0] STS_BAD_SIZE  = 4'd3;
   localparam logic [3:0] STS_NO_MEM    = 4'd4;
   localparam logic [3:0] STS_NO_LIST   = 4'd5;
   localparam logic [3:0] STS_FULL      = 4'd6;
   localparam logic [3:0] STS_EMPTY     = 4'd7;
   localparam logic [3:0] STS_ABSENT    = 4'd8;
   localparam logic [3:0] STS_BAD_NEW   = 4'd9;
   localparam logic [3:0] STS_ALL_EMPTY = 4'd10;

   typedef struct packed {
      logic          we;
      logic [AW-1:0] waddr;
      logic [31:0]   wdata;
      logic [AW-1:0] raddr;
   } store_req_type;

   function automatic logic [AW-1:0] slot_base(input logic [SW-1:0] i);
      return AW'(int'(i) * CAP);
   endfunction

   function automatic logic sgt(input logic [31:0] a, input logic [31:0] b);
      return $signed(a) > $signed(b);
   endfunction
endpackage

FILE: rtl/core/mlte_req_if.sv
// Command channel of the multi-list table engine.
// Depends on nothing but the handshake convention valid/ready.
interface mlte_req_if;
   logic              valid;
   logic              ready;
   logic [3:0]        kind;
   logic [3:0]        slot;
   logic signed [4:0] amount;
   logic signed [31:0] value;

   modport source (output valid, kind, slot, amount, value, input ready);
   modport sink   (input valid, kind, slot, amount, value, output ready);
endinterface

FILE: rtl/core/mlte_rsp_if.sv
// Result channel of the multi-list table engine.
// Depends on nothing but the handshake convention valid/ready.
interface mlte_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         status;
   logic signed [31:0] data_value;
   logic               has_value;
   logic [2:0]         item_count;
   logic               last;

   modport source (output valid, status, data_value, has_value, item_count, last,
                   input ready);
   modport sink   (input valid, status, data_value, has_value, item_count, last,
                   output ready);
endinterface

FILE: rtl/core/mlte_store.sv
// Element store: one write and one registered read a cycle.
// Depends on mlte_pkg.
module mlte_store (
   input  logic                   clock,
   input  mlte_pkg::store_req_type req,
   output logic [31:0]            rdata
);
   import mlte_pkg::*;

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.waddr] <= req.wdata;
      end
      rdata_ff <= mem_ff[req.raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/multi_list_table_engine.sv
// Channel   Dir  Handshake     Payload
// req_ifc   in   valid/ready   kind, slot, amount, value
// rsp_ifc   out  valid/ready   status, data_value, has_value, item_count, last
//
// One transaction at a time; req_ifc.ready is high only when idle.
// Status-only commands present their result the cycle after acceptance, except delete,
// which first reads and compares elements in order until a match, then shifts each later
// element down with a read and a write. A plain readout scans the positions in order and
// emits each element it finds; read all first tallies the counts of all slots. A sorted
// readout rescans once per distinct value and emits each copy of the current minimum.
// Synchronous reset clears the slot table; a stalled result holds the sequencer.
// Depends on mlte_pkg, mlte_req_if, mlte_rsp_if, mlte_store and the defines header.
`include "multi_list_table_engine_defines.svh"
module multi_list_table_engine (
   input  logic       clock,
   input  logic       reset,
   mlte_req_if.sink   req_ifc,
   mlte_rsp_if.source rsp_ifc
);
   import mlte_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b000000000001,
      ST_TOTAL      = 12'b000000000010,
      ST_PLAIN_RD   = 12'b000000000100,
      ST_PLAIN_DAT  = 12'b000000001000,
      ST_SORT_SCAN  = 12'b000000010000,
      ST_SORT_DRAIN = 12'b000000100000,
      ST_SORT_EMIT  = 12'b000001000000,
      ST_DEL_RD     = 12'b000010000000,
      ST_DEL_CMP    = 12'b000100000000,
      ST_SH_RD      = 12'b001000000000,
      ST_SH_WR      = 12'b010000000000,
      ST_OUT        = 12'b100000000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [3:0]    sts_ff, sts_in;
   logic [31:0]   data_ff, data_in;
   logic          has_ff, has_in;
   logic [2:0]    icnt_ff, icnt_in;
   logic          last_ff, last_in;
   logic [31:0]   value_ff, value_in;
   logic          sorted_ff, sorted_in, all_ff, all_in;
   logic [SW-1:0] s_ff, s_in;
   logic [KW-1:0] k_ff, k_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [NW-1:0] total_ff, total_in, done_ff, done_in, mcnt_ff, mcnt_in;
   logic [31:0]   min_ff, min_in, prev_ff, prev_in;
   logic          first_ff, first_in, have_ff, have_in, rdv_ff, rdv_in;
   logic [CW-1:0] cnt_ff [SLOTS];
   logic [CW-1:0] cnt_in [SLOTS];
   logic [CW-1:0] cap_ff [SLOTS];
   logic [CW-1:0] cap_in [SLOTS];
   logic [SLOTS-1:0] alloc_ff, alloc_in;

   store_req_type sreq;
   logic [31:0]   rdata;

   logic          idle, fire, slot_ok, cand, it_end, elig;
   logic [SW-1:0] req_idx, ridx, s_start;
   logic [CW-1:0] cur_cnt, cur_cap;
   logic          cur_alloc;
   logic [NW-1:0] tot;
   int            fin;

   mlte_store u_store (.clock(clock), .req(sreq), .rdata(rdata));

   assign idle    = (state_ff == ST_IDLE);
   assign fire    = req_ifc.valid && idle;
   assign slot_ok = (req_ifc.slot >= 4'd1) && (int'(req_ifc.slot) <= SLOTS);
   assign req_idx = SW'(req_ifc.slot - 4'd1);
   assign ridx    = idle ? (slot_ok ? req_idx : '0) : s_ff;
   assign cur_cnt   = cnt_ff[ridx];
   assign cur_cap   = cap_ff[ridx];
   assign cur_alloc = alloc_ff[ridx];
   assign cand   = cur_alloc && ((CW+1)'(k_ff) < (CW+1)'(cur_cnt));
   assign it_end = all_ff ? (int'(addr_ff) == DEPTH - 1) : (int'(k_ff) == CAP - 1);
   assign elig   = first_ff || sgt(rdata, prev_ff);
   assign s_start = all_ff ? '0 : s_ff;
   assign fin    = int'(cur_cap) + int'(req_ifc.amount);

   assign req_ifc.ready      = idle;
   assign rsp_ifc.valid      = (state_ff == ST_OUT);
   assign rsp_ifc.status     = sts_ff;
   assign rsp_ifc.data_value = data_ff;
   assign rsp_ifc.has_value  = has_ff;
   assign rsp_ifc.item_count = icnt_ff;
   assign rsp_ifc.last       = last_ff;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      sts_in   = sts_ff;
      data_in  = data_ff;
      has_in   = has_ff;
      icnt_in  = icnt_ff;
      last_in  = last_ff;
      value_in = value_ff;
      sorted_in = sorted_ff;
      all_in   = all_ff;
      s_in     = s_ff;
      k_in     = k_ff;
      addr_in  = addr_ff;
      total_in = total_ff;
      done_in  = done_ff;
      mcnt_in  = mcnt_ff;
      min_in   = min_ff;
      prev_in  = prev_ff;
      first_in = first_ff;
      have_in  = have_ff;
      rdv_in   = 1'b0;
      cnt_in   = cnt_ff;
      cap_in   = cap_ff;
      alloc_in = alloc_ff;
      tot      = '0;
      sreq.we    = 1'b0;
      sreq.waddr = addr_ff;
      sreq.wdata = rdata;
      sreq.raddr = addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (fire && req_ifc.kind <= K_CHECK) begin
               state_in = ST_OUT;
               ret_in   = ST_IDLE;
               sts_in   = STS_OK;
               data_in  = '0;
               has_in   = 1'b0;
               icnt_in  = '0;
               last_in  = 1'b1;
               value_in = req_ifc.value;
               if (req_ifc.kind == K_READ_ALL || req_ifc.kind == K_READ_ALL_SORT) begin
                  all_in    = 1'b1;
                  sorted_in = (req_ifc.kind == K_READ_ALL_SORT);
                  s_in      = '0;
                  total_in  = '0;
                  done_in   = '0;
                  state_in  = ST_TOTAL;
               end else if (!slot_ok) begin
                  sts_in = STS_BAD_POS;
               end else if (req_ifc.kind == K_CHECK) begin
                  sts_in = STS_OK;
               end else if (req_ifc.kind == K_CREATE) begin
                  if (cur_alloc) begin
                     sts_in = STS_EXISTS;
                  end else if (int'(req_ifc.amount) < 1) begin
                     sts_in = STS_BAD_SIZE;
                  end else if (int'(req_ifc.amount) > CAP) begin
                     sts_in = STS_NO_MEM;
                  end else begin
                     alloc_in[ridx] = 1'b1;
                     cnt_in[ridx]   = '0;
                     cap_in[ridx]   = CW'(req_ifc.amount);
                  end
               end else if (!cur_alloc) begin
                  sts_in = STS_NO_LIST;
               end else begin
                  case (req_ifc.kind)
                     K_APPEND: begin
                        if (cur_cnt >= cur_cap || int'(cur_cnt) >= CAP) begin
                           sts_in = STS_FULL;
                        end else begin
                           sreq.we      = 1'b1;
                           sreq.waddr   = slot_base(ridx) + AW'(cur_cnt);
                           sreq.wdata   = req_ifc.value;
                           cnt_in[ridx] = cur_cnt + CW'(1);
                        end
                     end
                     K_POP: begin
                        if (cur_cnt == '0) begin
                           sts_in = STS_EMPTY;
                        end else begin
                           cnt_in[ridx] = cur_cnt - CW'(1);
                        end
                     end
                     K_DELETE: begin
                        if (cur_cnt == '0) begin
                           sts_in = STS_EMPTY;
                        end else begin
                           s_in     = ridx;
                           k_in     = '0;
                           addr_in  = slot_base(ridx);
                           state_in = ST_DEL_RD;
                        end
                     end
                     K_RESIZE: begin
                        if (fin < 1) begin
                           sts_in = STS_BAD_NEW;
                        end else if (fin > CAP) begin
                           sts_in = STS_NO_MEM;
                        end else begin
                           cap_in[ridx] = CW'(fin);
                           if (int'(cur_cnt) > fin) begin
                              cnt_in[ridx] = CW'(fin);
                           end
                        end
                     end
                     K_COUNT: begin
                        if (cur_cnt == '0) begin
                           sts_in = STS_EMPTY;
                        end else begin
                           icnt_in = 3'(cur_cnt);
                        end
                     end
                     default: begin
                        all_in    = 1'b0;
                        sorted_in = (req_ifc.kind == K_READ_SORT);
                        if (cur_cnt != '0) begin
                           s_in     = ridx;
                           k_in     = '0;
                           addr_in  = slot_base(ridx);
                           total_in = NW'(cur_cnt);
                           done_in  = '0;
                           first_in = 1'b1;
                           have_in  = 1'b0;
                           state_in = (req_ifc.kind == K_READ_SORT) ? ST_SORT_SCAN
                                                                   : ST_PLAIN_RD;
                        end
                     end
                  endcase
               end
            end
         end

         ST_TOTAL: begin
            tot = total_ff + (cur_alloc ? NW'(cur_cnt) : NW'(0));
            if (int'(s_ff) == SLOTS - 1) begin
               if (tot == '0) begin
                  sts_in   = STS_ALL_EMPTY;
                  state_in = ST_OUT;
               end else begin
                  s_in     = '0;
                  k_in     = '0;
                  addr_in  = '0;
                  total_in = tot;
                  done_in  = '0;
                  first_in = 1'b1;
                  have_in  = 1'b0;
                  state_in = sorted_ff ? ST_SORT_SCAN : ST_PLAIN_RD;
               end
            end else begin
               s_in     = s_ff + SW'(1);
               total_in = tot;
            end
         end

         ST_PLAIN_RD: begin
            if (cand) begin
               state_in = ST_PLAIN_DAT;
            end else if (int'(k_ff) == CAP - 1) begin
               k_in    = '0;
               s_in    = s_ff + SW'(1);
               addr_in = addr_ff + AW'(1);
            end else begin
               k_in    = k_ff + KW'(1);
               addr_in = addr_ff + AW'(1);
            end
         end

         ST_PLAIN_DAT: begin
            sts_in   = STS_OK;
            data_in  = rdata;
            has_in   = 1'b1;
            icnt_in  = '0;
            last_in  = (done_ff + NW'(1) == total_ff);
            done_in  = done_ff + NW'(1);
            state_in = ST_OUT;
            ret_in   = ST_PLAIN_RD;
            if (!it_end) begin
               if (int'(k_ff) == CAP - 1) begin
                  k_in = '0;
                  s_in = s_ff + SW'(1);
               end else begin
                  k_in = k_ff + KW'(1);
               end
               addr_in = addr_ff + AW'(1);
            end
         end

         ST_SORT_SCAN, ST_SORT_DRAIN: begin
            if (rdv_ff && elig) begin
               if (!have_ff || sgt(min_ff, rdata)) begin
                  min_in  = rdata;
                  mcnt_in = NW'(1);
                  have_in = 1'b1;
               end else if (rdata == min_ff) begin
                  mcnt_in = mcnt_ff + NW'(1);
               end
            end
            if (state_ff == ST_SORT_DRAIN) begin
               state_in = ST_SORT_EMIT;
            end else begin
               rdv_in = cand;
               if (it_end) begin
                  state_in = ST_SORT_DRAIN;
               end else if (int'(k_ff) == CAP - 1) begin
                  k_in    = '0;
                  s_in    = s_ff + SW'(1);
                  addr_in = addr_ff + AW'(1);
               end else begin
                  k_in    = k_ff + KW'(1);
                  addr_in = addr_ff + AW'(1);
               end
            end
         end

         ST_SORT_EMIT: begin
            sts_in   = STS_OK;
            data_in  = min_ff;
            has_in   = 1'b1;
            icnt_in  = '0;
            last_in  = (done_ff + NW'(1) == total_ff);
            done_in  = done_ff + NW'(1);
            mcnt_in  = mcnt_ff - NW'(1);
            state_in = ST_OUT;
            ret_in   = ST_SORT_EMIT;
            if (mcnt_ff == NW'(1)) begin
               prev_in  = min_ff;
               first_in = 1'b0;
               have_in  = 1'b0;
               s_in     = s_start;
               k_in     = '0;
               addr_in  = slot_base(s_start);
               ret_in   = ST_SORT_SCAN;
            end
         end

         ST_DEL_RD: begin
            state_in = ST_DEL_CMP;
         end

         ST_DEL_CMP: begin
            if (rdata == value_ff) begin
               state_in = ST_SH_RD;
            end else if ((CW+1)'(k_ff) + (CW+1)'(1) < (CW+1)'(cur_cnt)) begin
               k_in     = k_ff + KW'(1);
               addr_in  = addr_ff + AW'(1);
               state_in = ST_DEL_RD;
            end else begin
               sts_in   = STS_ABSENT;
               state_in = ST_OUT;
            end
         end

         ST_SH_RD: begin
            sreq.raddr = addr_ff + AW'(1);
            if ((CW+1)'(k_ff) + (CW+1)'(1) < (CW+1)'(cur_cnt)) begin
               state_in = ST_SH_WR;
            end else begin
               cnt_in[ridx] = cur_cnt - CW'(1);
               sts_in   = STS_OK;
               state_in = ST_OUT;
            end
         end

         ST_SH_WR: begin
            sreq.we    = 1'b1;
            sreq.waddr = addr_ff;
            sreq.wdata = rdata;
            k_in       = k_ff + KW'(1);
            addr_in    = addr_ff + AW'(1);
            state_in   = ST_SH_RD;
         end

         ST_OUT: begin
            if (rsp_ifc.ready) begin
               state_in = last_ff ? ST_IDLE : ret_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         alloc_ff <= '0;
         total_ff <= '0;
         done_ff  <= '0;
         have_ff  <= 1'b0;
         rdv_ff   <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            cnt_ff[i] <= '0;
            cap_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         alloc_ff <= alloc_in;
         total_ff <= total_in;
         done_ff  <= done_in;
         have_ff  <= have_in;
         rdv_ff   <= rdv_in;
         cnt_ff   <= cnt_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      sts_ff    <= sts_in;
      data_ff   <= data_in;
      has_ff    <= has_in;
      icnt_ff   <= icnt_in;
      last_ff   <= last_in;
      value_ff  <= value_in;
      sorted_ff <= sorted_in;
      all_ff    <= all_in;
      s_ff      <= s_in;
      k_ff      <= k_in;
      addr_ff   <= addr_in;
      mcnt_ff   <= mcnt_in;
      min_ff    <= min_in;
      prev_ff   <= prev_in;
      first_ff  <= first_in;
   end

   `MLTE_ASSERT(a_rsp_blocks_req, clock, reset, rsp_ifc.valid |-> !req_ifc.ready)
   `MLTE_ASSERT(a_done_bounded, clock, reset, state_ff == ST_OUT |-> done_ff <= total_ff)
   `MLTE_ASSERT(a_sort_has_min, clock, reset, state_ff == ST_SORT_EMIT |-> have_ff && mcnt_ff != '0)
   `MLTE_ASSERT_NR(a_reset_idle, clock, $past(reset) |-> state_ff == ST_IDLE)
endmodule

FILE: verif/multi_list_table_engine_tb.sv
// Self-checking testbench of the multi-list table engine: directed and random
// commands, with results predicted in the bench and checked one by one.
// Depends on mlte_pkg, mlte_req_if, mlte_rsp_if and multi_list_table_engine.
`timescale 1ns / 100ps
module multi_list_table_engine_tb;
   import mlte_pkg::*;

   typedef struct {
      logic [3:0]         kind;
      logic [3:0]         slot;
      logic signed [4:0]  amount;
      logic signed [31:0] value;
      bit                 drain;
   } command_type;

   typedef struct {
      logic [3:0]  status;
      logic [31:0] data_value;
      logic        has_value;
      logic [2:0]  item_count;
      logic        last;
   } result_type;

   logic clock;
   logic reset;

   mlte_req_if req_if ();
   mlte_rsp_if rsp_if ();

   multi_list_table_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_ifc (req_if.sink),
      .rsp_ifc (rsp_if.source)
   );

   command_type pending_cmds[$];
   result_type  expected_results[$];

   logic [31:0] list_store [SLOTS*CAP];
   int          list_count [SLOTS];
   int          list_cap   [SLOTS];
   bit          list_live  [SLOTS];

   int  cmds_taken;
   int  errors;
   int  hold_cycles;
   bit  held_once;
   bit  took;

   logic signed [31:0] value_pool [8] = '{32'sd0, 32'sd1, -32'sd1, 32'sd7,
                                          32'h8000_0000, 32'h7fff_ffff,
                                          32'h5555_aaaa, -32'sd100};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void add_result(input logic [3:0] st, input logic [31:0] d,
                                      input logic h, input logic [2:0] c, input logic l);
      result_type r;
      r.status = st;
      r.data_value = d;
      r.has_value = h;
      r.item_count = c;
      r.last = l;
      expected_results.push_back(r);
   endfunction

   function automatic void emit_list(ref logic [31:0] vals[$], input bit sorted);
      logic [31:0] keep;
      int j;
      if (sorted) begin
         for (int i = 1; i < vals.size(); i++) begin
            keep = vals[i];
            j = i - 1;
            while (j >= 0 && $signed(vals[j]) > $signed(keep)) begin
               vals[j+1] = vals[j];
               j--;
            end
            vals[j+1] = keep;
         end
      end
      foreach (vals[i]) add_result(STS_OK, vals[i], 1'b1, 3'd0, i == vals.size() - 1);
   endfunction

   function automatic void apply_command(input logic [3:0] kind, input logic [3:0] slot,
                                         input logic signed [4:0] amount,
                                         input logic [31:0] value);
      logic [31:0] vals[$];
      int idx;
      int base;
      int found;
      int fin;
      if (kind > K_CHECK) return;
      if (kind == K_READ_ALL || kind == K_READ_ALL_SORT) begin
         for (int s = 0; s < SLOTS; s++)
            if (list_live[s])
               for (int k = 0; k < list_count[s]; k++) vals.push_back(list_store[s*CAP+k]);
         if (vals.size() == 0) add_result(STS_ALL_EMPTY, 0, 0, 0, 1);
         else emit_list(vals, kind == K_READ_ALL_SORT);
         return;
      end
      if (slot < 1 || slot > SLOTS) begin
         add_result(STS_BAD_POS, 0, 0, 0, 1);
         return;
      end
      if (kind == K_CHECK) begin
         add_result(STS_OK, 0, 0, 0, 1);
         return;
      end
      idx = slot - 1;
      base = idx * CAP;
      if (kind == K_CREATE) begin
         if (list_live[idx]) add_result(STS_EXISTS, 0, 0, 0, 1);
         else if (amount < 1) add_result(STS_BAD_SIZE, 0, 0, 0, 1);
         else if (amount > CAP) add_result(STS_NO_MEM, 0, 0, 0, 1);
         else begin
            list_live[idx] = 1;
            list_count[idx] = 0;
            list_cap[idx] = amount;
            add_result(STS_OK, 0, 0, 0, 1);
         end
         return;
      end
      if (!list_live[idx]) begin
         add_result(STS_NO_LIST, 0, 0, 0, 1);
         return;
      end
      case (kind)
         K_APPEND: begin
            if (list_count[idx] >= list_cap[idx]) add_result(STS_FULL, 0, 0, 0, 1);
            else begin
               list_store[base + list_count[idx]] = value;
               list_count[idx]++;
               add_result(STS_OK, 0, 0, 0, 1);
            end
         end
         K_POP: begin
            if (list_count[idx] == 0) add_result(STS_EMPTY, 0, 0, 0, 1);
            else begin
               list_count[idx]--;
               add_result(STS_OK, 0, 0, 0, 1);
            end
         end
         K_DELETE: begin
            found = -1;
            if (list_count[idx] == 0) add_result(STS_EMPTY, 0, 0, 0, 1);
            else begin
               for (int k = 0; k < list_count[idx] && found < 0; k++)
                  if (list_store[base+k] == value) found = k;
               if (found < 0) add_result(STS_ABSENT, 0, 0, 0, 1);
               else begin
                  for (int k = found; k + 1 < list_count[idx]; k++)
                     list_store[base+k] = list_store[base+k+1];
                  list_count[idx]--;
                  add_result(STS_OK, 0, 0, 0, 1);
               end
            end
         end
         K_RESIZE: begin
            fin = list_cap[idx] + amount;
            if (fin < 1) add_result(STS_BAD_NEW, 0, 0, 0, 1);
            else if (fin > CAP) add_result(STS_NO_MEM, 0, 0, 0, 1);
            else begin
               list_cap[idx] = fin;
               if (list_count[idx] > fin) list_count[idx] = fin;
               add_result(STS_OK, 0, 0, 0, 1);
            end
         end
         K_COUNT: begin
            if (list_count[idx] == 0) add_result(STS_EMPTY, 0, 0, 0, 1);
            else add_result(STS_OK, 0, 0, 3'(list_count[idx]), 1);
         end
         default: begin
            for (int k = 0; k < list_count[idx]; k++) vals.push_back(list_store[base+k]);
            if (vals.size() == 0) add_result(STS_OK, 0, 0, 0, 1);
            else emit_list(vals, kind == K_READ_SORT);
         end
      endcase
   endfunction

   function automatic void queue_command(input logic [3:0] kind, input int slot,
                                         input int amount, input logic [31:0] value,
                                         input bit drain = 0);
      command_type c;
      c.kind = kind;
      c.slot = 4'(slot);
      c.amount = 5'(amount);
      c.value = value;
      c.drain = drain;
      pending_cmds.push_back(c);
   endfunction

   function automatic void queue_random_command();
      int roll;
      int slot;
      int amount;
      logic [3:0] kind;
      logic [31:0] value;
      roll = $urandom_range(0, 99);
      if (roll < 14) kind = K_CREATE;
      else if (roll < 42) kind = K_APPEND;
      else if (roll < 50) kind = K_POP;
      else if (roll < 61) kind = K_DELETE;
      else if (roll < 68) kind = K_RESIZE;
      else if (roll < 74) kind = K_COUNT;
      else if (roll < 80) kind = K_READ;
      else if (roll < 86) kind = K_READ_SORT;
      else if (roll < 90) kind = K_READ_ALL;
      else if (roll < 94) kind = K_READ_ALL_SORT;
      else if (roll < 97) kind = K_CHECK;
      else kind = 4'($urandom_range(11, 15));
      slot = ($urandom_range(0, 99) < 88) ? $urandom_range(1, SLOTS) : $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 80)
         amount = (kind == K_CREATE) ? $urandom_range(1, CAP) : $urandom_range(0, 6) - 3;
      else
         amount = $urandom_range(0, 31);
      value = ($urandom_range(0, 99) < 65) ? value_pool[$urandom_range(0, 7)] : $urandom();
      queue_command(kind, slot, amount, value);
   endfunction

   function automatic int idle_percent(input bit sender);
      if (cmds_taken < 55) return sender ? 12 : 49;
      if (cmds_taken < 100) return sender ? 49 : 12;
      return 0;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         apply_command(req_if.kind, req_if.slot, req_if.amount, req_if.value);
         cmds_taken <= cmds_taken + 1;
         took <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || took) begin
         took <= 1'b0;
         if (pending_cmds.size() == 0 ||
             (pending_cmds[0].drain && expected_results.size() != 0) ||
             $urandom_range(0, 99) < idle_percent(1)) begin
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid  <= 1'b1;
            req_if.kind   <= pending_cmds[0].kind;
            req_if.slot   <= pending_cmds[0].slot;
            req_if.amount <= pending_cmds[0].amount;
            req_if.value  <= pending_cmds[0].value;
            void'(pending_cmds.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (!held_once && cmds_taken >= 40) begin
         rsp_if.ready <= 1'b0;
         held_once <= 1'b1;
         hold_cycles <= 300;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= idle_percent(0));
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d data=%h has=%0d count=%0d last=%0d",
                     $time, rsp_if.status, rsp_if.data_value, rsp_if.has_value,
                     rsp_if.item_count, rsp_if.last);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.status !== want.status || rsp_if.data_value !== want.data_value ||
                rsp_if.has_value !== want.has_value || rsp_if.item_count !== want.item_count ||
                rsp_if.last !== want.last) begin
               $display("%0t: expected status=%0d data=%h has=%0d count=%0d last=%0d",
                        $time, want.status, want.data_value, want.has_value,
                        want.item_count, want.last);
               $display("%0t: actual   status=%0d data=%h has=%0d count=%0d last=%0d",
                        $time, rsp_if.status, rsp_if.data_value, rsp_if.has_value,
                        rsp_if.item_count, rsp_if.last);
               errors++;
            end
         end
      end
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.kind = '0;
      req_if.slot = '0;
      req_if.amount = '0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      cmds_taken = 0;
      errors = 0;
      hold_cycles = 0;
      held_once = 0;
      took = 0;
      foreach (list_live[i]) begin
         list_live[i] = 0;
         list_count[i] = 0;
         list_cap[i] = 0;
      end
      reset = 1'b1;

      queue_command(K_READ_ALL, 0, 0, 0);
      queue_command(K_CHECK, 0, 0, 0);
      queue_command(K_CHECK, 15, 0, 0);
      queue_command(K_CHECK, SLOTS, 0, 0);
      queue_command(K_APPEND, 3, 0, 5);
      queue_command(K_CREATE, 1, 0, 0);
      queue_command(K_CREATE, 1, -16, 0);
      queue_command(K_CREATE, 1, 15, 0);
      queue_command(K_CREATE, 1, CAP, 0);
      queue_command(K_CREATE, 1, 2, 0);
      queue_command(K_COUNT, 1, 0, 0);
      queue_command(K_READ, 1, 0, 0);
      queue_command(K_POP, 1, 0, 0);
      queue_command(K_DELETE, 1, 0, 0);
      foreach (value_pool[i]) queue_command(K_APPEND, 1, 0, value_pool[i]);
      queue_command(K_DELETE, 1, 0, 32'h1234_5678);
      queue_command(K_DELETE, 1, 0, 32'hffff_ffff);
      queue_command(K_RESIZE, 1, -16, 0);
      queue_command(K_RESIZE, 1, 15, 0);
      queue_command(K_RESIZE, 1, -3, 0);
      queue_command(K_COUNT, 1, 0, 0);
      queue_command(K_READ_SORT, 1, 0, 0);
      queue_command(K_READ_ALL_SORT, 0, 0, 0);
      queue_command(4'd15, 1, 0, 0);
      for (int i = 0; i < 80; i++) begin
         if (i == 40) queue_command(K_READ_ALL, 0, 0, 0, 1);
         queue_random_command();
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_cmds.size() == 0 && !req_if.valid);
      wait (expected_results.size() == 0);
      repeat (4000) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/mlte_pkg.sv
rtl/core/mlte_req_if.sv
rtl/core/mlte_rsp_if.sv
rtl/core/mlte_store.sv
rtl/core/multi_list_table_engine.sv
verif/multi_list_table_engine_tb.sv
